// ===== rtl/kdcr_pkg.sv =====
// Shared types, constants and register codes for the key debounce block.
package kdcr_pkg;

   // Running time width default
   localparam int TIME_BITS_DEFAULT = 32;

   // Configuration port geometry
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_RECHECK_INTERVAL    = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_KEY_ID              = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DEBOUNCE_TIME       = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_LONG_PRESS_TIME     = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_REPEAT_PERIOD       = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DOUBLE_CLICK_WINDOW = 3'd5;

   // Register reset values
   localparam logic [15:0] RECHECK_INTERVAL_RESET    = 16'd0;
   localparam logic [7:0]  KEY_ID_RESET              = 8'd0;
   localparam logic [7:0]  DEBOUNCE_TIME_RESET       = 8'd20;
   localparam logic [15:0] LONG_PRESS_TIME_RESET     = 16'd400;
   localparam logic [7:0]  REPEAT_PERIOD_RESET       = 8'd80;
   localparam logic [15:0] DOUBLE_CLICK_WINDOW_RESET = 16'd200;

   // Counter saturation limits
   localparam logic [15:0] PRESS_TIME_MAX   = 16'hFFFF;
   localparam logic [7:0]  RELEASE_TIME_MAX = 8'hFF;
   localparam logic [8:0]  REPEAT_TIME_MAX  = 9'h1FF;

   // One result item
   typedef struct packed {
      logic [7:0] event_key;
      logic       down_event;
      logic       double_click_event;
      logic       repeat_event;
      logic       up_event;
      logic       held;
      logic       released;
   } rsp_type;

endpackage

// ===== rtl/kdcr_core.sv =====
// Key state registers, configuration registers and the per-scan update logic.
module kdcr_core #(
   parameter int TIME_BITS = kdcr_pkg::TIME_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [kdcr_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [kdcr_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic                                step,
   input  logic [7:0]                          scan_interval,
   input  logic                                key_pressed,
   output kdcr_pkg::rsp_type                   result
);

   // Configuration registers
   logic [15:0] recheck_ff;
   logic [7:0]  key_id_ff;
   logic [7:0]  debounce_ff;
   logic [15:0] long_press_ff;
   logic [7:0]  period_ff;
   logic [15:0] window_ff;

   // Key state registers
   logic [TIME_BITS-1:0] time_ff, time_in;
   logic [15:0]          press_ff, press_in;
   logic [7:0]           release_ff, release_in;
   logic [8:0]           repeat_ff, repeat_in;
   logic                 phase_ff, phase_in;
   logic [TIME_BITS-1:0] start_ff, start_in;
   logic [TIME_BITS-1:0] end_ff, end_in;
   logic                 held_ff, held_in;
   logic                 long_ff, long_in;
   logic                 released_ff, released_in;

   // Intermediate sums and flags
   logic [16:0]          press_sum;
   logic [15:0]          press_sat;
   logic [8:0]           release_sum;
   logic [7:0]           release_sat;
   logic [9:0]           repeat_sum;
   logic [8:0]           repeat_sat;
   logic [TIME_BITS-1:0] gap;
   logic                 down, dbl, rep, up;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         recheck_ff    <= kdcr_pkg::RECHECK_INTERVAL_RESET;
         key_id_ff     <= kdcr_pkg::KEY_ID_RESET;
         debounce_ff   <= kdcr_pkg::DEBOUNCE_TIME_RESET;
         long_press_ff <= kdcr_pkg::LONG_PRESS_TIME_RESET;
         period_ff     <= kdcr_pkg::REPEAT_PERIOD_RESET;
         window_ff     <= kdcr_pkg::DOUBLE_CLICK_WINDOW_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            kdcr_pkg::REG_RECHECK_INTERVAL:    recheck_ff    <= csr_wdata;
            kdcr_pkg::REG_KEY_ID:              key_id_ff     <= csr_wdata[7:0];
            kdcr_pkg::REG_DEBOUNCE_TIME:       debounce_ff   <= csr_wdata[7:0];
            kdcr_pkg::REG_LONG_PRESS_TIME:     long_press_ff <= csr_wdata;
            kdcr_pkg::REG_REPEAT_PERIOD:       period_ff     <= csr_wdata[7:0];
            kdcr_pkg::REG_DOUBLE_CLICK_WINDOW: window_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Saturating counter sums
   assign press_sum   = {1'b0, press_ff} + {9'b0, scan_interval};
   assign press_sat   = press_sum[16] ? kdcr_pkg::PRESS_TIME_MAX : press_sum[15:0];
   assign release_sum = {1'b0, release_ff} + {1'b0, scan_interval};
   assign release_sat = release_sum[8] ? kdcr_pkg::RELEASE_TIME_MAX : release_sum[7:0];

   // Compute next state and event flags for one scan
   always_comb begin
      time_in     = time_ff + TIME_BITS'(scan_interval);
      press_in    = press_ff;
      release_in  = release_ff;
      repeat_in   = repeat_ff;
      phase_in    = phase_ff;
      start_in    = start_ff;
      end_in      = end_ff;
      held_in     = held_ff;
      long_in     = long_ff;
      released_in = released_ff;
      gap         = '0;
      repeat_sum  = '0;
      repeat_sat  = '0;
      down        = 1'b0;
      dbl         = 1'b0;
      rep         = 1'b0;
      up          = 1'b0;
      if (key_pressed) begin
         press_in = press_sat;
         // accept a debounced press and stamp it
         if (press_sat >= {8'b0, debounce_ff} && !held_ff) begin
            held_in     = 1'b1;
            released_in = 1'b0;
            release_in  = '0;
            phase_in    = ~phase_ff;
            if (!phase_ff) begin
               start_in = time_in;
            end else begin
               end_in = time_in;
            end
            if (end_in > start_in) begin
               gap = end_in - start_in;
            end else begin
               gap = start_in - end_in;
            end
            down = (gap != '0) && (gap > TIME_BITS'(recheck_ff));
            dbl  = (gap != '0) && (gap < TIME_BITS'(window_ff));
         end
         if (press_sat >= long_press_ff) begin
            long_in = 1'b1;
         end
         // advance the repeat counter while long pressed
         if (long_in) begin
            repeat_sum = {1'b0, repeat_ff} + {2'b0, scan_interval};
            repeat_sat = (repeat_sum > {1'b0, kdcr_pkg::REPEAT_TIME_MAX}) ?
                         kdcr_pkg::REPEAT_TIME_MAX : repeat_sum[8:0];
            if (repeat_sat >= {1'b0, period_ff}) begin
               rep       = 1'b1;
               repeat_in = '0;
            end else begin
               repeat_in = repeat_sat;
            end
         end
      end else begin
         // accept a debounced release and drop the press state
         if (release_sat >= debounce_ff) begin
            release_in  = debounce_ff;
            released_in = 1'b1;
            up          = held_ff;
            press_in    = '0;
            repeat_in   = '0;
            held_in     = 1'b0;
            long_in     = 1'b0;
         end else begin
            release_in = release_sat;
         end
      end
   end

   // Update key state on each accepted scan
   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff     <= '0;
         press_ff    <= '0;
         release_ff  <= '0;
         repeat_ff   <= '0;
         phase_ff    <= 1'b0;
         start_ff    <= '0;
         end_ff      <= '0;
         held_ff     <= 1'b0;
         long_ff     <= 1'b0;
         released_ff <= 1'b0;
      end else if (step) begin
         time_ff     <= time_in;
         press_ff    <= press_in;
         release_ff  <= release_in;
         repeat_ff   <= repeat_in;
         phase_ff    <= phase_in;
         start_ff    <= start_in;
         end_ff      <= end_in;
         held_ff     <= held_in;
         long_ff     <= long_in;
         released_ff <= released_in;
      end
   end

   // Assemble the result item
   always_comb begin
      result.event_key          = key_id_ff;
      result.down_event         = down;
      result.double_click_event = dbl;
      result.repeat_event       = rep;
      result.up_event           = up;
      result.held               = held_in;
      result.released           = released_in;
   end

endmodule

// ===== rtl/kdcr_out_buf.sv =====
// Two-entry result buffer that decouples the scan side from the receiver.
module kdcr_out_buf (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  kdcr_pkg::rsp_type push_data,
   output logic              not_full,
   output logic              pop_valid,
   input  logic              pop_ready,
   output kdcr_pkg::rsp_type pop_data
);

   kdcr_pkg::rsp_type entry_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              pop;

   assign not_full  = (count_ff != 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop       = pop_valid && pop_ready;
   assign pop_data  = entry_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold result payloads
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/key_debounce_click_repeat.sv =====
// Top level of the debounced key with double click and long-press repeat.
//
// Each transfer on the req_ channel is one scan of the key: the time elapsed
// since the previous scan and the raw pressed level. Each scan yields exactly
// one transfer on the rsp_ channel carrying the key id, the down,
// double-click, repeat and up flags, and the debounced held and released
// levels after that scan.
// The scan is folded into the key state in the cycle it is accepted and its
// result is written to a two-entry output buffer, from which it is offered
// on rsp_. One scan is taken every cycle while the buffer has room; req_ready
// drops only while both buffer entries wait on the receiver, and rises again
// in the cycle after one of them is taken.
// Reset clears the running time, the counters, the press stamps and the
// buffer, and loads the register defaults (debounce 20, long press 400,
// repeat 80, double-click window 200, re-check 0, key id 0). The user writes
// registers through csr_we, csr_index and csr_wdata only while the block is
// idle, unenforced by the block; writes to an index above five are ignored.
module key_debounce_click_repeat #(
   parameter int TIME_BITS = kdcr_pkg::TIME_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [kdcr_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [kdcr_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [7:0]                          req_scan_interval,
   input  logic                                req_key_pressed,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [7:0]                          rsp_event_key,
   output logic                                rsp_down_event,
   output logic                                rsp_double_click_event,
   output logic                                rsp_repeat_event,
   output logic                                rsp_up_event,
   output logic                                rsp_held,
   output logic                                rsp_released
);

   logic              step;
   kdcr_pkg::rsp_type result;
   kdcr_pkg::rsp_type rsp_data;

   // Take a scan whenever one is offered and the buffer has room
   assign step = req_valid && req_ready;

   kdcr_core #(
      .TIME_BITS(TIME_BITS)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .step          (step),
      .scan_interval (req_scan_interval),
      .key_pressed   (req_key_pressed),
      .result        (result)
   );

   kdcr_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (step),
      .push_data (result),
      .not_full  (req_ready),
      .pop_valid (rsp_valid),
      .pop_ready (rsp_ready),
      .pop_data  (rsp_data)
   );

   // Unpack the result item onto its ports
   assign rsp_event_key          = rsp_data.event_key;
   assign rsp_down_event         = rsp_data.down_event;
   assign rsp_double_click_event = rsp_data.double_click_event;
   assign rsp_repeat_event       = rsp_data.repeat_event;
   assign rsp_up_event           = rsp_data.up_event;
   assign rsp_held               = rsp_data.held;
   assign rsp_released           = rsp_data.released;

endmodule

// ===== rtl/kdcr_checker.sv =====
// Port-level checks for the key debounce block and their bind.
module kdcr_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_down_event,
   input logic rsp_double_click_event,
   input logic rsp_up_event,
   input logic rsp_held,
   input logic rsp_released
);

   // No result is offered right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered after reset");

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // Debounced levels are exclusive
   a_levels: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_held && rsp_released))
      else $error("held and released both set");

   // An up transfer leaves the key released
   a_up_released: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_up_event |-> rsp_released && !rsp_held)
      else $error("up event without release");

   // Press events leave the key held
   a_press_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_down_event || rsp_double_click_event) |-> rsp_held)
      else $error("press event without held level");

endmodule

bind key_debounce_click_repeat kdcr_checker u_kdcr_checker (
   .clock                  (clock),
   .reset                  (reset),
   .rsp_valid              (rsp_valid),
   .rsp_ready              (rsp_ready),
   .rsp_down_event         (rsp_down_event),
   .rsp_double_click_event (rsp_double_click_event),
   .rsp_up_event           (rsp_up_event),
   .rsp_held               (rsp_held),
   .rsp_released           (rsp_released)
);
